@@ rtl/core/rdc_pkg.sv @@
// Shared types, constants and helper functions of the radix digit converter.
`default_nettype none

package rdc_pkg;

	// Field widths
	localparam int VALUE_W    = 63;
	localparam int RADIX_W    = 5;
	localparam int CHAR_W     = 7;
	localparam int DIGIT_W    = 4;

	// Digit stack
	localparam int MAX_DIGITS = 64;
	localparam int DIG_AW     = $clog2(MAX_DIGITS);

	// Long division: STEP_BITS dividend bits are retired per cycle
	localparam int STEP_BITS  = 8;
	localparam int DIV_CYC    = (VALUE_W + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W      = DIV_CYC * STEP_BITS;
	localparam int STEP_CW    = $clog2(DIV_CYC);

	// Job queue between front and back
	localparam int QDEPTH     = 2;
	localparam int QAW        = $clog2(QDEPTH);

	// Configuration port
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int REGIDX_W   = PADDR_W - 2;
	localparam logic [REGIDX_W-1:0] REG_RADIX = REGIDX_W'(0);

	localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] BASE_MIN  = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] BASE_MAX  = RADIX_W'(16);

	localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(8'h41);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

	// One conversion job as classified by the front
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] base;
	} job_t;

	// Clamp the programmed radix into the supported range
	function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		b = r;
		if (r < BASE_MIN) begin
			b = BASE_MIN;
		end else if (r > BASE_MAX) begin
			b = BASE_MAX;
		end
		return b;
	endfunction

	// Map a digit value to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/radix_digit_converter.sv @@
// Top level of the radix digit converter: front end, job queue and conversion engine.
// Each digit takes a long division of the 64-bit padded dividend, 8 dividend bits per cycle.
// Characters then leave via a digit stack read, then an output register load, once it is free.
// The engine takes no new value until the last is sent; the queue holds two more meanwhile.
// Reset: arst_n clears all control state and the radix register returns to 10.
`default_nettype none

module radix_digit_converter import rdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               push,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    full,
	output logic                    empty,
	input  wire logic               pop,
	output logic      [CHAR_W-1:0]  digit_char,
	output logic                    last
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t in_job;
	job_t out_job;

	rdc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.value   (value),
		.full    (full),
		.q_push  (q_push),
		.q_job   (in_job),
		.q_full  (q_full)
	);

	rdc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (in_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (out_job),
		.empty    (q_empty)
	);

	rdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (out_job),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

`default_nettype wire

@@ rtl/core/rdc_front.sv @@
// Front end: radix register on the APB port, input acceptance and job classification.
`default_nettype none

module rdc_front import rdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// input items
	input  wire logic               push,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    full,
	// job queue
	output logic                    q_push,
	output job_t                    q_job,
	input  wire logic               q_full
);

	logic [RADIX_W-1:0]  radix_q;
	logic [REGIDX_W-1:0] reg_idx;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	// Write the radix register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RST;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_RADIX) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	// Read back
	assign prdata = (reg_idx == REG_RADIX) ? PDATA_W'(radix_q) : '0;

	// Classify: attach the clamped base to the value
	assign full        = q_full;
	assign q_push      = push && !q_full;
	assign q_job.value = value;
	assign q_job.base  = eff_base(radix_q);

endmodule

`default_nettype wire

@@ rtl/core/rdc_queue.sv @@
// Short job queue that decouples the front end from the conversion engine.
`default_nettype none

module rdc_queue import rdc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      pop_job,
	output logic      empty
);

	job_t             slot_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = slot_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold job payloads
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rdc_back.sv @@
// Conversion engine: digit-serial division into a digit stack, then most significant first output.
`default_nettype none

module rdc_back import rdc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// job queue
	input  wire logic              q_empty,
	input  job_t                   q_job,
	output logic                   q_pop,
	// results
	output logic                   empty,
	input  wire logic              pop,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_SEND
	} state_t;

	state_t               state_q;
	logic [DIV_W-1:0]     n_q;
	logic [RADIX_W-1:0]   base_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [STEP_CW-1:0]   step_q;
	logic [DIG_AW-1:0]    cnt_q;
	logic [DIG_AW-1:0]    ptr_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;

	logic [DIGIT_W-1:0]   dig_mem [MAX_DIGITS];
	logic [DIGIT_W-1:0]   rd_data_q;

	logic [DIGIT_W-1:0]   rem_c;
	logic [DIGIT_W:0]     trial_c;
	logic [STEP_BITS-1:0] quo_c;
	logic [DIV_W-1:0]     n_next;
	logic                 last_step;
	logic                 div_done;
	logic                 out_free;

	// Retire STEP_BITS dividend bits: restoring division by a base of at most 16
	always_comb begin
		rem_c   = rem_q;
		trial_c = '0;
		quo_c   = '0;
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			trial_c = {rem_c, n_q[DIV_W-STEP_BITS+i]};
			if (trial_c >= base_q) begin
				trial_c  = trial_c - base_q;
				quo_c[i] = 1'b1;
			end
			rem_c = trial_c[DIGIT_W-1:0];
		end
	end

	assign n_next    = {n_q[DIV_W-STEP_BITS-1:0], quo_c};
	assign last_step = (step_q == STEP_CW'(DIV_CYC-1));
	assign div_done  = (n_next == '0) || (cnt_q == DIG_AW'(MAX_DIGITS-1));
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign out_free  = !out_valid_q || pop;

	// Digit stack: push remainders, read back from the top
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && last_step) begin
			dig_mem[cnt_q] <= rem_c;
		end
		rd_data_q <= dig_mem[ptr_q];
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			base_q      <= BASE_MIN;
			rem_q       <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= CHAR_ZERO;
			out_last_q  <= 1'b0;
		end else begin
			// drop the result once taken; the send state reloads it itself
			if (out_valid_q && pop && state_q != S_SEND) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						n_q     <= DIV_W'(q_job.value);
						base_q  <= q_job.base;
						rem_q   <= '0;
						step_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					n_q <= n_next;
					if (last_step) begin
						step_q <= '0;
						rem_q  <= '0;
						if (div_done) begin
							ptr_q   <= cnt_q;
							state_q <= S_READ;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						rem_q  <= rem_c;
						step_q <= step_q + 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= digit_to_char(rd_data_q);
						out_last_q  <= (ptr_q == '0);
						if (ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty      = !out_valid_q;
	assign digit_char = out_char_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/rdc_checker.sv @@
// Port-level checks of the radix digit converter, bound to the top level.
`default_nettype none

module rdc_checker import rdc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              pop,
	input wire logic [CHAR_W-1:0] digit_char,
	input wire logic              last
);

	// Nothing waits on the result side while in reset
	assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result side not empty during reset");

	// Queue has room right after reset
	assert property (@(posedge clk) $rose(arst_n) |-> !full)
		else $error("input side full after reset");

	// A waiting result that is not taken holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digit_char) && $stable(last)))
		else $error("pending result changed or vanished");

	// Only digit characters leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((digit_char >= 7'h30 && digit_char <= 7'h39) ||
			(digit_char >= 7'h41 && digit_char <= 7'h46)))
		else $error("result is not a digit character");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

`default_nettype wire

@@ verif/radix_digit_converter_checker.sv @@
// Checker for the radix digit converter: tracks the radix register, predicts characters, compares.
`timescale 1ns / 1ps

module radix_digit_converter_checker import rdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic [PDATA_W-1:0] prdata,
	input  wire logic               pready,
	input  wire logic               push,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               full,
	input  wire logic               empty,
	input  wire logic               pop,
	input  wire logic [CHAR_W-1:0]  digit_char,
	input  wire logic               last,
	output int                      error_count,
	output int                      chars_waiting
);

	localparam logic [CHAR_W-1:0] ASCII_ZERO    = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = CHAR_W'(8'h41);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              lst;
	} digit_entry_t;

	logic [RADIX_W-1:0] radix_setting;
	digit_entry_t       expected_chars [$];

	initial begin
		error_count   = 0;
		chars_waiting = 0;
		radix_setting = RADIX_RST;
	end

	// Count a failure and report it
	task automatic note_failure(input string msg);
		error_count++;
		$display("%0t: %s", $time, msg);
	endtask

	// Divide down by the clamped base and queue the characters, most significant first
	task automatic predict_digits(input logic [VALUE_W-1:0] number);
		logic [63:0]        rest;
		logic [63:0]        divisor;
		logic [DIGIT_W-1:0] digit_stack [MAX_DIGITS];
		int                 n_digits;
		digit_entry_t       entry;
		rest = 64'(number);
		if (radix_setting < BASE_MIN) begin
			divisor = 64'(BASE_MIN);
		end else if (radix_setting > BASE_MAX) begin
			divisor = 64'(BASE_MAX);
		end else begin
			divisor = 64'(radix_setting);
		end
		n_digits = 0;
		do begin
			digit_stack[n_digits] = DIGIT_W'(rest % divisor);
			n_digits++;
			rest = rest / divisor;
		end while (rest != 0 && n_digits < MAX_DIGITS);
		for (int k = n_digits - 1; k >= 0; k--) begin
			if (digit_stack[k] < DIGIT_W'(10)) begin
				entry.ch = ASCII_ZERO + CHAR_W'(digit_stack[k]);
			end else begin
				entry.ch = ASCII_UPPER_A + CHAR_W'(digit_stack[k] - DIGIT_W'(10));
			end
			entry.lst = (k == 0);
			expected_chars.push_back(entry);
		end
	endtask

	always @(posedge clk) begin
		digit_entry_t want;
		if (!arst_n) begin
			radix_setting = RADIX_RST;
			expected_chars.delete();
		end else begin
			// Track register writes; writes to unused addresses change nothing
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_RADIX) begin
				radix_setting = pwdata[RADIX_W-1:0];
			end
			// Read back the radix register
			if (psel && penable && !pwrite && pready && paddr[PADDR_W-1:2] == REG_RADIX) begin
				if (prdata !== PDATA_W'(radix_setting)) begin
					note_failure($sformatf("radix readback: expected %h, got %h",
						PDATA_W'(radix_setting), prdata));
				end
			end
			// Compare each result transaction with the oldest expected character
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					note_failure($sformatf("unexpected char: expected none, got %h last %b",
						digit_char, last));
				end else begin
					want = expected_chars.pop_front();
					if (digit_char !== want.ch) begin
						note_failure($sformatf("digit_char: expected %h, got %h",
							want.ch, digit_char));
					end
					if (last !== want.lst) begin
						note_failure($sformatf("last: expected %b, got %b", want.lst, last));
					end
				end
			end
			// Predict the characters of each accepted input transaction
			if (push && !full) begin
				predict_digits(value);
			end
		end
		chars_waiting = expected_chars.size();
	end

endmodule

@@ verif/radix_digit_converter_tb.sv @@
// Testbench top for the radix digit converter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module radix_digit_converter_tb;
	import rdc_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_RADIX     = {REG_RADIX, 2'b00};
	// No register lives here; writes must be ignored
	localparam logic [PADDR_W-1:0] ADDR_UNUSED    = PADDR_W'(4);
	localparam logic [VALUE_W-1:0] VALUE_MAX      = {VALUE_W{1'b1}};
	localparam int                 WATCHDOG_LIMIT = 5000;
	localparam int                 RANDOM_ITEMS   = 160;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               push;
	logic [VALUE_W-1:0] value;
	logic               full;
	logic               empty;
	logic               pop;
	logic [CHAR_W-1:0]  digit_char;
	logic               last;

	int error_count;
	int chars_waiting;
	int sender_idle_pct;
	int receiver_idle_pct;
	int stalled_cycles;

	radix_digit_converter uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .value(value), .full(full),
		.empty(empty), .pop(pop), .digit_char(digit_char), .last(last)
	);

	radix_digit_converter_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .value(value), .full(full),
		.empty(empty), .pop(pop), .digit_char(digit_char), .last(last),
		.error_count(error_count), .chars_waiting(chars_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: take results at random, stall as the current phase asks
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || psel) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	// Offer one value, idling first at random, and hold it until accepted
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Hold off the sender until every expected character has come out
	task automatic drain_results();
		push <= 1'b0;
		@(negedge clk);
		while (chars_waiting != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// One APB transaction: setup cycle, then access cycle until pready
	task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reprogram a register once idle, then read the radix back
	task automatic program_register(input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		drain_results();
		apb_transfer(1'b1, addr, data);
		@(negedge clk);
		apb_transfer(1'b0, ADDR_RADIX, $urandom);
	endtask

	// Pick a radix, leaning on the clamp ranges and the extremes
	function automatic logic [RADIX_W-1:0] pick_radix();
		logic [RADIX_W-1:0] r;
		case ($urandom_range(0, 9))
			0: r = BASE_MIN;
			1: r = BASE_MAX;
			2: r = RADIX_W'($urandom_range(0, 1));
			3: r = RADIX_W'($urandom_range(17, 31));
			default: r = RADIX_W'($urandom_range(2, 16));
		endcase
		return r;
	endfunction

	// Random value with a random bit length, plus the occasional extreme
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1: v = VALUE_MAX;
			default: v = VALUE_W'({$urandom, $urandom}) >> $urandom_range(0, VALUE_W - 1);
		endcase
		return v;
	endfunction

	initial begin
		int sent;
		int burst;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		push              = 1'b0;
		value             = '0;
		pop               = 1'b0;
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset radix is ten: zero, single digits, carry to two digits, largest value
		apb_transfer(1'b0, ADDR_RADIX, '0);
		send_value('0);
		send_value(VALUE_W'(1));
		send_value(VALUE_W'(9));
		send_value(VALUE_W'(10));
		send_value(VALUE_W'(64'd12345678901234567));
		send_value(VALUE_MAX);

		// Hex: every letter digit, the carry at sixteen
		program_register(ADDR_RADIX, PDATA_W'(16));
		send_value(VALUE_W'(64'h7EDC_BA98_7654_3210));
		send_value(VALUE_W'(15));
		send_value(VALUE_W'(16));
		send_value(VALUE_MAX);

		// Binary: the longest digit string
		program_register(ADDR_RADIX, PDATA_W'(2));
		send_value(VALUE_MAX);
		send_value(VALUE_W'(1));
		send_value(VALUE_W'(64'h4000_0000_0000_0000));

		// Radix below two acts as binary
		program_register(ADDR_RADIX, PDATA_W'(0));
		send_value(VALUE_W'(6));
		program_register(ADDR_RADIX, PDATA_W'(1));
		send_value(VALUE_W'(5));

		// Radix above sixteen acts as hex
		program_register(ADDR_RADIX, PDATA_W'(17));
		send_value(VALUE_W'(255));
		program_register(ADDR_RADIX, PDATA_W'(31));
		send_value(VALUE_W'(4095));

		// Upper data bits are dropped: this sets base three
		program_register(ADDR_RADIX, 32'hFFFF_FFE3);
		send_value(VALUE_MAX);

		// Write to an unused address leaves base three in place
		program_register(ADDR_UNUSED, PDATA_W'(5));
		send_value(VALUE_W'(8));

		// Random bursts under three idling mixes, reprogramming between bursts
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct   = 14;
					receiver_idle_pct = 47;
				end
				1: begin
					sender_idle_pct   = 47;
					receiver_idle_pct = 14;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS) begin
				if ($urandom_range(0, 7) == 0) begin
					program_register(ADDR_UNUSED, $urandom);
				end
				program_register(ADDR_RADIX,
					{(PDATA_W-RADIX_W)'($urandom_range(0, 134217727)), pick_radix()});
				burst = $urandom_range(8, 30);
				for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
					send_value(pick_value());
					sent++;
				end
			end
		end

		// Wait out the last characters, then allow a little quiet time
		drain_results();
		repeat (50) @(negedge clk);
		if (error_count == 0 && chars_waiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
